>>> sv/md5sh_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// md5sh_pkg
// Shared types, constants and round tables for the MD5 stream hash unit.
// ----------------------------------------------------------------------------
package md5sh_pkg;

    localparam logic [31:0] INIT_A = 32'h67452301;
    localparam logic [31:0] INIT_B = 32'hefcdab89;
    localparam logic [31:0] INIT_C = 32'h98badcfe;
    localparam logic [31:0] INIT_D = 32'h10325476;
    localparam logic [7:0]  PAD_BYTE = 8'h80;
    localparam logic        ACT_DATA = 1'b0;
    localparam logic        ACT_FINISH = 1'b1;

    typedef struct packed {
        logic       action;
        logic [7:0] data_byte;
    } md5sh_in_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [1:0]  word_index;
        logic        last_word;
    } md5sh_out_t;

    typedef struct packed {
        logic       start;
        logic       busy;
    } md5sh_ctl_t;

    function automatic logic [31:0] k_add(input logic [5:0] s);
        logic [31:0] k;
        case (s)
            6'd0: k = 32'hd76aa478; 6'd1: k = 32'he8c7b756; 6'd2: k = 32'h242070db;
            6'd3: k = 32'hc1bdceee; 6'd4: k = 32'hf57c0faf; 6'd5: k = 32'h4787c62a;
            6'd6: k = 32'ha8304613; 6'd7: k = 32'hfd469501; 6'd8: k = 32'h698098d8;
            6'd9: k = 32'h8b44f7af; 6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193; 6'd14: k = 32'ha679438e;
            6'd15: k = 32'h49b40821; 6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa; 6'd20: k = 32'hd62f105d;
            6'd21: k = 32'h02441453; 6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6; 6'd26: k = 32'hf4d50d87;
            6'd27: k = 32'h455a14ed; 6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a; 6'd32: k = 32'hfffa3942;
            6'd33: k = 32'h8771f681; 6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9; 6'd38: k = 32'hf6bb4b60;
            6'd39: k = 32'hbebfbc70; 6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05; 6'd44: k = 32'hd9d4d039;
            6'd45: k = 32'he6db99e5; 6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97; 6'd50: k = 32'hab9423a7;
            6'd51: k = 32'hfc93a039; 6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1; 6'd56: k = 32'h6fa87e4f;
            6'd57: k = 32'hfe2ce6e0; 6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235; 6'd62: k = 32'h2ad7d2bb;
            default: k = 32'heb86d391;
        endcase
        return k;
    endfunction

    function automatic logic [3:0] msg_sel(input logic [5:0] s);
        logic [3:0] i;
        i = s[3:0];
        case (s[5:4])
            2'd0: msg_sel = i;
            2'd1: msg_sel = 4'(5 * i + 1);
            2'd2: msg_sel = 4'(3 * i + 5);
            default: msg_sel = 4'(7 * i);
        endcase
    endfunction

    function automatic logic [4:0] rot_amt(input logic [5:0] s);
        logic [4:0] r;
        case ({s[5:4], s[1:0]})
            4'd0: r = 5'd7;   4'd1: r = 5'd12;  4'd2: r = 5'd17;  4'd3: r = 5'd22;
            4'd4: r = 5'd5;   4'd5: r = 5'd9;   4'd6: r = 5'd14;  4'd7: r = 5'd20;
            4'd8: r = 5'd4;   4'd9: r = 5'd11;  4'd10: r = 5'd16; 4'd11: r = 5'd23;
            4'd12: r = 5'd6;  4'd13: r = 5'd10; 4'd14: r = 5'd15; default: r = 5'd21;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

>>> sv/md5sh_round.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// md5sh_round
// Compression datapath: working registers A to D and one MD5 step per cycle while busy.
// ----------------------------------------------------------------------------
module md5sh_round (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire md5sh_pkg::md5sh_ctl_t ctl,
    input  wire logic [5:0]           step,
    input  wire logic [31:0]          msg_word,
    input  wire logic [127:0]         chain,
    output logic      [127:0]         sum
);
    import md5sh_pkg::*;

    logic [31:0] a_reg, b_reg, c_reg, d_reg;
    logic [31:0] f, t, r;

    always_comb
    begin
        case (step[5:4])
            2'd0: f = d_reg ^ (b_reg & (c_reg ^ d_reg));
            2'd1: f = c_reg ^ (d_reg & (b_reg ^ c_reg));
            2'd2: f = b_reg ^ c_reg ^ d_reg;
            default: f = c_reg ^ (b_reg | ~d_reg);
        endcase
        t = a_reg + f + msg_word + k_add(step);
        r = ((t << rot_amt(step)) | (t >> (6'd32 - {1'b0, rot_amt(step)}))) + b_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_reg <= '0; b_reg <= '0; c_reg <= '0; d_reg <= '0;
        end
        else if (ctl.start)
        begin
            {a_reg, b_reg, c_reg, d_reg} <= chain;
        end
        else if (ctl.busy)
        begin
            a_reg <= d_reg; d_reg <= c_reg; c_reg <= b_reg; b_reg <= r;
        end
    end

    assign sum = {chain[127:96] + a_reg, chain[95:64] + b_reg,
                  chain[63:32] + c_reg, chain[31:0] + d_reg};
endmodule
`default_nettype wire

>>> sv/md5_stream_hash_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// md5_stream_hash_unit
// Byte-serial MD5 engine with a sixteen-word block memory.
// ----------------------------------------------------------------------------
// Each data byte is accepted, then its buffer word is read and the merged
// word is written back. A full block is then compressed: the working
// registers are loaded and the first message word read, 64 rounds run at
// one per cycle with each next message word read in the cycle before its
// round, and the chaining words are folded in. A finish reads and then
// writes the padding word, writes the zero fill and the length one word
// per cycle, runs one or two blocks and then offers the four digest words
// in order, one per cycle unless stalled. The block memory with one read
// and one write port and the shared round unit set this schedule.
module md5_stream_hash_unit (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire md5sh_pkg::md5sh_in_t   in_data,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output md5sh_pkg::md5sh_out_t       out_data
);
    import md5sh_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE, ST_RD, ST_WR, ST_PAD_RD, ST_PAD_WR, ST_ZERO, ST_LEN,
        ST_PRE, ST_RUN, ST_FOLD, ST_OUT
    } state_t;

    state_t      state_reg;
    logic [31:0] mem [16];
    logic [31:0] rd_reg;
    logic [127:0] chain_reg;
    logic [63:0] count_reg;
    logic [7:0]  byte_reg;
    logic        finish_reg, second_reg;
    logic [3:0]  widx_reg;
    logic [5:0]  step_reg;
    logic [1:0]  oidx_reg;
    logic        mem_we;
    logic [3:0]  mem_wa, mem_ra;
    logic [31:0] mem_wd, merged;
    logic [127:0] sum;
    logic [63:0] bits;
    md5sh_ctl_t  ctl;
    logic [1:0]  bsel;

    assign bits = {count_reg[60:0], 3'b000};
    assign bsel = count_reg[1:0];

    always_comb
    begin
        merged = rd_reg;
        case (bsel)
            2'd0: merged[7:0] = byte_reg;
            2'd1: merged[15:8] = byte_reg;
            2'd2: merged[23:16] = byte_reg;
            default: merged[31:24] = byte_reg;
        endcase
        if (state_reg == ST_PAD_WR)
        begin
            case (bsel)
                2'd0: merged = {24'd0, PAD_BYTE};
                2'd1: merged = {16'd0, PAD_BYTE, rd_reg[7:0]};
                2'd2: merged = {8'd0, PAD_BYTE, rd_reg[15:0]};
                default: merged = {PAD_BYTE, rd_reg[23:0]};
            endcase
        end
    end

    always_comb
    begin
        mem_we = 1'b0;
        mem_wa = widx_reg;
        mem_wd = merged;
        mem_ra = count_reg[5:2];
        case (state_reg)
            ST_WR, ST_PAD_WR: mem_we = 1'b1;
            ST_ZERO:
            begin
                mem_we = 1'b1;
                mem_wd = '0;
            end
            ST_LEN:
            begin
                mem_we = 1'b1;
                mem_wd = widx_reg[0] ? bits[63:32] : bits[31:0];
            end
            ST_PRE, ST_RUN: mem_ra = msg_sel(state_reg == ST_PRE ? 6'd0 : step_reg + 6'd1);
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_wa] <= mem_wd;
        rd_reg <= mem[mem_ra];
    end

    assign ctl.start = (state_reg == ST_PRE);
    assign ctl.busy  = (state_reg == ST_RUN);

    md5sh_round u_round (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (ctl),
        .step    (step_reg),
        .msg_word(rd_reg),
        .chain   (chain_reg),
        .sum     (sum)
    );

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = (state_reg == ST_OUT);
    always_comb
    begin
        case (oidx_reg)
            2'd0: out_data.digest_word = chain_reg[127:96];
            2'd1: out_data.digest_word = chain_reg[95:64];
            2'd2: out_data.digest_word = chain_reg[63:32];
            default: out_data.digest_word = chain_reg[31:0];
        endcase
        out_data.word_index = oidx_reg;
        out_data.last_word  = (oidx_reg == 2'd3);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            chain_reg  <= {INIT_A, INIT_B, INIT_C, INIT_D};
            count_reg  <= '0;
            finish_reg <= 1'b0;
            second_reg <= 1'b0;
            widx_reg   <= '0;
            step_reg   <= '0;
            oidx_reg   <= '0;
            byte_reg   <= '0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                    if (in_valid)
                    begin
                        byte_reg <= in_data.data_byte;
                        widx_reg <= count_reg[5:2];
                        state_reg <= (in_data.action == ACT_FINISH) ? ST_PAD_RD : ST_RD;
                    end
                ST_RD: state_reg <= ST_WR;
                ST_WR:
                begin
                    count_reg <= count_reg + 64'd1;
                    finish_reg <= 1'b0;
                    state_reg <= (count_reg[5:0] == 6'd63) ? ST_PRE : ST_IDLE;
                end
                ST_PAD_RD: state_reg <= ST_PAD_WR;
                ST_PAD_WR:
                begin
                    finish_reg <= 1'b1;
                    second_reg <= (count_reg[5:0] >= 6'd56);
                    if (widx_reg == 4'd15)
                        state_reg <= (count_reg[5:0] >= 6'd56) ? ST_PRE : ST_LEN;
                    else
                    begin
                        widx_reg <= widx_reg + 4'd1;
                        state_reg <= (widx_reg == 4'd13) && (count_reg[5:0] < 6'd56)
                                     ? ST_LEN : ST_ZERO;
                    end
                end
                ST_ZERO:
                    if (widx_reg == 4'd15)
                        state_reg <= second_reg ? ST_PRE : ST_LEN;
                    else if (widx_reg == 4'd13 && !second_reg)
                    begin
                        widx_reg <= 4'd14;
                        state_reg <= ST_LEN;
                    end
                    else
                        widx_reg <= widx_reg + 4'd1;
                ST_LEN:
                    if (widx_reg == 4'd15)
                        state_reg <= ST_PRE;
                    else
                        widx_reg <= widx_reg + 4'd1;
                ST_PRE:
                begin
                    step_reg <= '0;
                    state_reg <= ST_RUN;
                end
                ST_RUN:
                begin
                    step_reg <= step_reg + 6'd1;
                    if (step_reg == 6'd63)
                        state_reg <= ST_FOLD;
                end
                ST_FOLD:
                begin
                    chain_reg <= sum;
                    if (!finish_reg)
                        state_reg <= ST_IDLE;
                    else if (second_reg)
                    begin
                        second_reg <= 1'b0;
                        widx_reg <= '0;
                        state_reg <= ST_ZERO;
                    end
                    else
                    begin
                        oidx_reg <= '0;
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT:
                    if (!out_stall)
                    begin
                        oidx_reg <= oidx_reg + 2'd1;
                        if (oidx_reg == 2'd3)
                        begin
                            chain_reg <= {INIT_A, INIT_B, INIT_C, INIT_D};
                            count_reg <= '0;
                            finish_reg <= 1'b0;
                            state_reg <= ST_IDLE;
                        end
                    end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_no_in_when_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall) else $error("input taken during digest output");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
        else $error("digest word changed while stalled");
    a_run_len: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PRE) |=> (state_reg == ST_RUN && step_reg == 6'd0))
        else $error("compression did not start at step zero");
`endif
endmodule
`default_nettype wire

>>> sim/tb_md5_stream_hash_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_md5_stream_hash_unit
// Self-checking testbench for the byte-serial MD5 stream hash unit.
// ----------------------------------------------------------------------------
// A directed table of messages and finish transactions runs first, with the
// known first digest word of the empty message typed in. Random messages follow,
// with block and padding boundaries favored. Every digest word is compared
// with a behavioral MD5 model kept in the testbench, or with the typed word
// where one is given, while the input idles and the output stalls at random.
module tb_md5_stream_hash_unit;
    import md5sh_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 400;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    md5sh_in_t in_data = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    md5sh_out_t out_data;

    typedef struct {
        md5sh_in_t   item;
        logic        typed;
        logic [31:0] word0;
    } dir_row_t;

    logic [31:0] hash_chain [4];
    logic [31:0] msg_block [16];
    logic [63:0] msg_bytes;
    md5sh_out_t  digest_q [$];
    logic [31:0] typed_word0_q [$];
    md5sh_in_t   stim_q [$];
    dir_row_t    dir_rows [$];
    int          mismatches = 0;
    int          idle_cycles = 0;
    bit          stim_done = 1'b0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    md5_stream_hash_unit i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data(out_data)
    );

    function automatic logic [31:0] round_const(int s);
        return 32'(longint'($floor($pow(2.0, 32.0) * (($sin(real'(s + 1)) < 0.0) ?
            -$sin(real'(s + 1)) : $sin(real'(s + 1))))));
    endfunction

    function automatic void md5_compress();
        logic [31:0] a, b, c, d, f, t;
        int g, r;
        int shifts [16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};
        a = hash_chain[0];
        b = hash_chain[1];
        c = hash_chain[2];
        d = hash_chain[3];
        for (int s = 0; s < 64; s++)
        begin
            case (s / 16)
                0: begin f = (b & c) | (~b & d); g = s; end
                1: begin f = (d & b) | (~d & c); g = (5 * s + 1) % 16; end
                2: begin f = b ^ c ^ d; g = (3 * s + 5) % 16; end
                default: begin f = c ^ (b | ~d); g = (7 * s) % 16; end
            endcase
            r = shifts[(s / 16) * 4 + s % 4];
            t = a + f + msg_block[g] + round_const(s);
            t = ((t << r) | (t >> (32 - r))) + b;
            a = d;
            d = c;
            c = b;
            b = t;
        end
        hash_chain[0] += a;
        hash_chain[1] += b;
        hash_chain[2] += c;
        hash_chain[3] += d;
    endfunction

    function automatic void set_block_byte(int pos, logic [7:0] v);
        msg_block[pos / 4][(pos % 4) * 8 +: 8] = v;
    endfunction

    function automatic void restart_hash();
        hash_chain = '{INIT_A, INIT_B, INIT_C, INIT_D};
        msg_bytes = '0;
    endfunction

    function automatic void hash_accept(md5sh_in_t it);
        int pos;
        logic [63:0] bits;
        md5sh_out_t o;
        pos = int'(msg_bytes[5:0]);
        if (it.action == ACT_DATA)
        begin
            set_block_byte(pos, it.data_byte);
            msg_bytes++;
            if (pos == 63)
                md5_compress();
            return;
        end
        bits = msg_bytes << 3;
        set_block_byte(pos, PAD_BYTE);
        for (int i = pos + 1; i < 64; i++)
            set_block_byte(i, 8'h00);
        if (pos > 55)
        begin
            md5_compress();
            for (int i = 0; i < 16; i++)
                msg_block[i] = '0;
        end
        msg_block[14] = bits[31:0];
        msg_block[15] = bits[63:32];
        md5_compress();
        for (int i = 0; i < 4; i++)
        begin
            o.digest_word = hash_chain[i];
            o.word_index = 2'(i);
            o.last_word = (i == 3);
            digest_q.push_back(o);
        end
        restart_hash();
    endfunction

    function automatic md5sh_in_t data_item(logic [7:0] v);
        md5sh_in_t it;
        it.action = ACT_DATA;
        it.data_byte = v;
        return it;
    endfunction

    function automatic md5sh_in_t finish_item(logic [7:0] v);
        md5sh_in_t it;
        it.action = ACT_FINISH;
        it.data_byte = v;
        return it;
    endfunction

    function automatic int gap_len();
        if ($urandom_range(0, 9) < 6)
            return 0;
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic add_row(md5sh_in_t it, logic typed, logic [31:0] w0);
        dir_row_t r;
        r.item = it;
        r.typed = typed;
        r.word0 = w0;
        dir_rows.push_back(r);
    endtask

    task automatic send_item(md5sh_in_t it);
        int g;
        g = gap_len();
        if (g > 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(negedge clk);
        end
        in_data <= it;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        hash_accept(it);
        @(negedge clk);
    endtask

    initial
    begin
        int len;
        restart_hash();
        for (int i = 0; i < 16; i++)
            msg_block[i] = '0;
        // Empty message, finish after finish, and a set data field on a finish.
        add_row(finish_item(8'h00), 1'b1, 32'hd98c1dd4);
        add_row(finish_item(8'hff), 1'b1, 32'hd98c1dd4);
        add_row(data_item(8'h00), 1'b0, '0);
        add_row(data_item(8'hff), 1'b0, '0);
        add_row(data_item(8'h61), 1'b0, '0);
        add_row(finish_item(8'haa), 1'b0, '0);
        add_row(data_item(8'h80), 1'b0, '0);
        add_row(data_item(8'h7f), 1'b0, '0);
        add_row(data_item(8'h55), 1'b0, '0);
        add_row(finish_item(8'h00), 1'b0, '0);
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        foreach (dir_rows[i])
        begin
            if (dir_rows[i].typed)
                typed_word0_q.push_back(dir_rows[i].word0);
            send_item(dir_rows[i].item);
        end
        // Messages sized around the padding and block boundaries.
        while (stim_q.size() < 355)
        begin
            case ($urandom_range(0, 5))
                0: len = $urandom_range(54, 57);
                1: len = $urandom_range(62, 65);
                2: len = $urandom_range(118, 121);
                3: len = $urandom_range(126, 130);
                default: len = $urandom_range(0, 20);
            endcase
            if (stim_q.size() + len + 1 > 360)
                len = 360 - stim_q.size() - 1;
            for (int j = 0; j < len; j++)
                stim_q.push_back(data_item(8'($urandom)));
            stim_q.push_back(finish_item(8'($urandom)));
        end
        while (stim_q.size() > 0)
            send_item(stim_q.pop_front());
        in_valid <= 1'b0;
        stim_done = 1'b1;
    end

    // Output stall, mostly short with a long stretch now and then.
    initial
    begin
        forever
        begin
            @(negedge clk);
            if ($urandom_range(0, 99) < 3)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(10, 40)) @(negedge clk);
            end
            else
                out_stall <= ($urandom_range(0, 9) < 3);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (digest_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected digest transaction %h", out_data);
            end
            else
            begin
                md5sh_out_t e;
                e = digest_q.pop_front();
                if (e.word_index == 2'd0 && typed_word0_q.size() > 0)
                    e.digest_word = typed_word0_q.pop_front();
                if (out_data !== e)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Digest mismatch: expected %h/%0d/%0d, got %h/%0d/%0d",
                            e.digest_word, e.word_index, e.last_word,
                            out_data.digest_word, out_data.word_index,
                            out_data.last_word);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        wait (stim_done);
        while (digest_q.size() > 0 && idle_cycles < WATCHDOG_LIMIT)
            @(posedge clk);
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && digest_q.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        wait (rst_n);
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("TEST FAILED");
        $finish;
    end

endmodule
